>>> rtl/cpcr_pkg.sv
package cpcr_pkg;

    localparam int RADIUS_WIDTH = 16;
    localparam int DAMP_WIDTH   = 17;
    localparam int DAMP_SHIFT   = 16;
    localparam logic [DAMP_WIDTH-1:0] DAMP_RESET = 17'd62915;

    localparam int F_APX = 0;
    localparam int F_APY = 1;
    localparam int F_AVX = 2;
    localparam int F_AVY = 3;
    localparam int F_BPX = 4;
    localparam int F_BPY = 5;
    localparam int F_BVX = 6;
    localparam int F_BVY = 7;
    localparam int NUM_FIELDS = 8;

endpackage

>>> rtl/cpcr_delay.sv
module cpcr_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    generate
        if (DEPTH == 0) begin : g_pass
            assign dout = din;
        end else begin : g_line
            logic [W-1:0] dly_reg [DEPTH];

            always_ff @(posedge aclk) begin
                if (en) begin
                    dly_reg[0] <= din;
                    for (int i = 1; i < DEPTH; i++) begin
                        dly_reg[i] <= dly_reg[i-1];
                    end
                end
            end

            assign dout = dly_reg[DEPTH-1];
        end
    endgenerate

endmodule

>>> rtl/cpcr_isqrt.sv
module cpcr_isqrt #(
    parameter int RTW = 17
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [2*RTW-1:0] value,
    output logic [RTW-1:0]   root
);

    logic [2*RTW-1:0] rem_reg  [RTW];
    logic [RTW-1:0]   root_reg [RTW];

    generate
        for (genvar k = 0; k < RTW; k++) begin : g_st
            localparam int I = RTW - 1 - k;
            logic [2*RTW-1:0] rem_in;
            logic [RTW-1:0]   root_in;
            logic [2*RTW:0]   term;

            if (k == 0) begin : g_first
                assign rem_in  = value;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            assign term = ({{(RTW+1){1'b0}}, root_in} << (I + 1))
                        + ((2*RTW+1)'(1) << (2 * I));

            always_ff @(posedge aclk) begin
                if (en) begin
                    if ({1'b0, rem_in} >= term) begin
                        rem_reg[k]  <= rem_in - term[2*RTW-1:0];
                        root_reg[k] <= root_in | (RTW'(1) << I);
                    end else begin
                        rem_reg[k]  <= rem_in;
                        root_reg[k] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[RTW-1];

endmodule

>>> rtl/cpcr_div.sv
module cpcr_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int XW = (NW > DW + QW) ? NW : DW + QW;

    logic [XW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    generate
        for (genvar k = 0; k < QW; k++) begin : g_st
            localparam int I = QW - 1 - k;
            logic [XW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [XW-1:0] dsh;

            if (k == 0) begin : g_first
                assign rem_in = XW'(num);
                assign den_in = den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            assign dsh = XW'(den_in) << I;

            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[k] <= den_in;
                    if (rem_in >= dsh) begin
                        rem_reg[k] <= rem_in - dsh;
                        quo_reg[k] <= quo_in | (QW'(1) << I);
                    end else begin
                        rem_reg[k] <= rem_in;
                        quo_reg[k] <= quo_in;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QW-1];

endmodule

>>> rtl/circle_pair_collision_resolve_unit.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    two discs: centre, velocity, radius
// m_       out  m_valid/m_ready    resolved centres and velocities, collided
// cfg_     in   cfg_wr_en          damping factor, unsigned Q1.16
//
// One item per cycle sustained while the skid register is empty; the output register is the
// last register before m_valid, and the square root and the two divider paths set the pipeline
// depth from acceptance to m_valid.
// Reset clears the pipeline valid bits and the output and skid valid flags and loads the damping default.
// A stall holds the whole pipeline; the skid register catches the item leaving it,
// so s_ready is registered and nothing is lost or repeated.
module circle_pair_collision_resolve_unit #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [cpcr_pkg::DAMP_WIDTH-1:0]       cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_WIDTH-1:0]         s_first_pos_x,
    input  logic signed [COORD_WIDTH-1:0]         s_first_pos_y,
    input  logic signed [COORD_WIDTH-1:0]         s_first_vel_x,
    input  logic signed [COORD_WIDTH-1:0]         s_first_vel_y,
    input  logic [cpcr_pkg::RADIUS_WIDTH-1:0]     s_first_radius,
    input  logic signed [COORD_WIDTH-1:0]         s_second_pos_x,
    input  logic signed [COORD_WIDTH-1:0]         s_second_pos_y,
    input  logic signed [COORD_WIDTH-1:0]         s_second_vel_x,
    input  logic signed [COORD_WIDTH-1:0]         s_second_vel_y,
    input  logic [cpcr_pkg::RADIUS_WIDTH-1:0]     s_second_radius,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [COORD_WIDTH-1:0]         m_new_first_pos_x,
    output logic signed [COORD_WIDTH-1:0]         m_new_first_pos_y,
    output logic signed [COORD_WIDTH-1:0]         m_new_first_vel_x,
    output logic signed [COORD_WIDTH-1:0]         m_new_first_vel_y,
    output logic signed [COORD_WIDTH-1:0]         m_new_second_pos_x,
    output logic signed [COORD_WIDTH-1:0]         m_new_second_pos_y,
    output logic signed [COORD_WIDTH-1:0]         m_new_second_vel_x,
    output logic signed [COORD_WIDTH-1:0]         m_new_second_vel_y,
    output logic                                  m_collided
);

    localparam int CW    = COORD_WIDTH;
    localparam int NF    = cpcr_pkg::NUM_FIELDS;
    localparam int RW    = cpcr_pkg::RADIUS_WIDTH;
    localparam int DMW   = cpcr_pkg::DAMP_WIDTH;
    localparam int SW    = RW + 1;
    localparam int DXW   = CW + 1;
    localparam int EXW   = (DXW > SW + 1) ? DXW : SW + 1;
    localparam int D2W   = 2 * CW + 1;
    localparam int CMPW  = (D2W > 2 * SW) ? D2W : 2 * SW;
    localparam int DOTW  = CW + SW + 3;
    localparam int MW    = DOTW - 1;
    localparam int LOW   = (MW + 1) / 2;
    localparam int HIW   = MW - LOW;
    localparam int NWP   = MW + SW + 1;
    localparam int QWP   = CW + 2;
    localparam int NWU   = 2 * SW + 1;
    localparam int QWU   = SW;
    localparam int LAT_U = 2 * SW + 1;
    localparam int LAT_P = QWP + 2;
    localparam int LAT_M = (LAT_U > LAT_P) ? LAT_U : LAT_P;
    localparam int TOTAL = LAT_M + 6;
    localparam int PLW   = NF * CW + SW + DXW + 5;
    localparam int PXW   = CW + 3;
    localparam int VW    = CW + 4;
    localparam int PDW   = VW + DMW + 1;
    localparam int PSW   = ((CW > SW + 1) ? CW : SW + 1) + 1;
    localparam int SATW  = VW + 24;
    localparam int OW    = NF * CW + 1;

    function automatic logic [CW-1:0] sat_c(input logic signed [SATW-1:0] v);
        logic signed [SATW-1:0] hi;
        logic signed [SATW-1:0] lo;
        hi = {{(SATW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    logic             adv;
    logic [TOTAL-1:0] vld_reg;
    logic [DMW-1:0]   damp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damp_reg <= cpcr_pkg::DAMP_RESET;
        end else if (cfg_wr_en) begin
            damp_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_valid};
        end
    end

    // stage A: differences and radius sum
    logic [CW-1:0]        a_fld_reg [NF];
    logic signed [DXW-1:0] a_dx_reg, a_dy_reg, a_rvx_reg, a_rvy_reg;
    logic [SW-1:0]        a_s_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_fld_reg[cpcr_pkg::F_APX] <= s_first_pos_x;
            a_fld_reg[cpcr_pkg::F_APY] <= s_first_pos_y;
            a_fld_reg[cpcr_pkg::F_AVX] <= s_first_vel_x;
            a_fld_reg[cpcr_pkg::F_AVY] <= s_first_vel_y;
            a_fld_reg[cpcr_pkg::F_BPX] <= s_second_pos_x;
            a_fld_reg[cpcr_pkg::F_BPY] <= s_second_pos_y;
            a_fld_reg[cpcr_pkg::F_BVX] <= s_second_vel_x;
            a_fld_reg[cpcr_pkg::F_BVY] <= s_second_vel_y;
            a_dx_reg  <= DXW'(s_first_pos_x) - DXW'(s_second_pos_x);
            a_dy_reg  <= DXW'(s_first_pos_y) - DXW'(s_second_pos_y);
            a_rvx_reg <= DXW'(s_first_vel_x) - DXW'(s_second_vel_x);
            a_rvy_reg <= DXW'(s_first_vel_y) - DXW'(s_second_vel_y);
            a_s_reg   <= SW'(s_first_radius) + SW'(s_second_radius);
        end
    end

    // stage B: squares and dot product terms
    logic signed [EXW-1:0]   a_dxe, a_dye;
    logic signed [SW:0]      a_dxh, a_dyh;
    logic signed [2*DXW-1:0] sqx_full, sqy_full;
    logic signed [DOTW-2:0]  pdx_full, pdy_full;

    assign a_dxe    = EXW'(a_dx_reg);
    assign a_dye    = EXW'(a_dy_reg);
    assign a_dxh    = a_dxe[SW:0];
    assign a_dyh    = a_dye[SW:0];
    assign sqx_full = a_dx_reg * a_dx_reg;
    assign sqy_full = a_dy_reg * a_dy_reg;
    assign pdx_full = a_rvx_reg * a_dxh;
    assign pdy_full = a_rvy_reg * a_dyh;

    logic [CW-1:0]          b_fld_reg [NF];
    logic signed [DXW-1:0]  b_rvx_reg;
    logic signed [SW:0]     b_dxh_reg, b_dyh_reg;
    logic                   b_sdx_reg, b_sdy_reg;
    logic [SW-1:0]          b_s_reg;
    logic [2*CW-1:0]        b_sqx_reg, b_sqy_reg;
    logic [2*SW-1:0]        b_s2_reg;
    logic signed [DOTW-2:0] b_pdx_reg, b_pdy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_fld_reg <= a_fld_reg;
            b_rvx_reg <= a_rvx_reg;
            b_dxh_reg <= a_dxh;
            b_dyh_reg <= a_dyh;
            b_sdx_reg <= a_dx_reg[DXW-1];
            b_sdy_reg <= a_dy_reg[DXW-1];
            b_s_reg   <= a_s_reg;
            b_sqx_reg <= sqx_full[2*CW-1:0];
            b_sqy_reg <= sqy_full[2*CW-1:0];
            b_s2_reg  <= a_s_reg * a_s_reg;
            b_pdx_reg <= pdx_full;
            b_pdy_reg <= pdy_full;
        end
    end

    // stage C: distance squared, overlap test, dot product
    logic [D2W-1:0] b_d2;
    logic [CMPW-1:0] b_d2x;
    logic [SW:0]    b_adx_full, b_ady_full;

    assign b_d2       = D2W'(b_sqx_reg) + D2W'(b_sqy_reg);
    assign b_d2x      = CMPW'(b_d2);
    assign b_adx_full = b_dxh_reg[SW] ? -b_dxh_reg : b_dxh_reg;
    assign b_ady_full = b_dyh_reg[SW] ? -b_dyh_reg : b_dyh_reg;

    logic [CW-1:0]          c_fld_reg [NF];
    logic signed [DXW-1:0]  c_rvx_reg;
    logic                   c_sdx_reg, c_sdy_reg, c_hit_reg, c_zero_reg;
    logic [SW-1:0]          c_s_reg, c_adx_reg, c_ady_reg;
    logic [CMPW-1:0]        c_d2_reg;
    logic signed [DOTW-1:0] c_dot_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_fld_reg  <= b_fld_reg;
            c_rvx_reg  <= b_rvx_reg;
            c_sdx_reg  <= b_sdx_reg;
            c_sdy_reg  <= b_sdy_reg;
            c_s_reg    <= b_s_reg;
            c_adx_reg  <= b_adx_full[SW-1:0];
            c_ady_reg  <= b_ady_full[SW-1:0];
            c_d2_reg   <= b_d2x;
            c_hit_reg  <= b_d2x < CMPW'(b_s2_reg);
            c_zero_reg <= (b_d2 == '0);
            c_dot_reg  <= DOTW'(b_pdx_reg) + DOTW'(b_pdy_reg);
        end
    end

    // push path: distance, depth, push quotient
    logic [SW-1:0]   u_dist;
    logic [3*SW-1:0] u_side;
    logic [SW-1:0]   u_adx, u_ady, u_s;

    cpcr_isqrt #(.RTW(SW)) u_isqrt (
        .aclk  (aclk),
        .en    (adv),
        .value (c_d2_reg[2*SW-1:0]),
        .root  (u_dist)
    );

    cpcr_delay #(.W(3 * SW), .DEPTH(SW)) u_side_dly (
        .aclk (aclk),
        .en   (adv),
        .din  ({c_adx_reg, c_ady_reg, c_s_reg}),
        .dout (u_side)
    );

    assign {u_adx, u_ady, u_s} = u_side;

    logic [SW-1:0]  u_depth;
    logic [NWU-1:0] u_nx_reg, u_ny_reg;
    logic [SW:0]    u_den_reg;

    assign u_depth = u_s - u_dist;

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_nx_reg  <= NWU'(u_adx * u_depth) + NWU'(u_dist);
            u_ny_reg  <= NWU'(u_ady * u_depth) + NWU'(u_dist);
            u_den_reg <= {u_dist, 1'b0};
        end
    end

    logic [QWU-1:0] qux, quy, qux_al, quy_al;

    cpcr_div #(.NW(NWU), .DW(SW + 1), .QW(QWU)) u_div_ux (
        .aclk (aclk), .en (adv), .num (u_nx_reg), .den (u_den_reg), .quo (qux)
    );

    cpcr_div #(.NW(NWU), .DW(SW + 1), .QW(QWU)) u_div_uy (
        .aclk (aclk), .en (adv), .num (u_ny_reg), .den (u_den_reg), .quo (quy)
    );

    cpcr_delay #(.W(2 * QWU), .DEPTH(LAT_M - LAT_U)) u_u_dly (
        .aclk (aclk),
        .en   (adv),
        .din  ({qux, quy}),
        .dout ({qux_al, quy_al})
    );

    // velocity path: projection of relative velocity on the normal
    logic [DOTW-1:0] c_dot_abs;
    logic [MW-1:0]   c_dot_mag;

    assign c_dot_abs = c_dot_reg[DOTW-1] ? -c_dot_reg : c_dot_reg;
    assign c_dot_mag = c_dot_abs[MW-1:0];

    logic [LOW+SW-1:0] d_lx_reg, d_ly_reg;
    logic [HIW+SW-1:0] d_hx_reg, d_hy_reg;
    logic [2*SW-1:0]   d_d2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_lx_reg <= c_dot_mag[LOW-1:0] * c_adx_reg;
            d_ly_reg <= c_dot_mag[LOW-1:0] * c_ady_reg;
            d_hx_reg <= c_dot_mag[MW-1:LOW] * c_adx_reg;
            d_hy_reg <= c_dot_mag[MW-1:LOW] * c_ady_reg;
            d_d2_reg <= c_d2_reg[2*SW-1:0];
        end
    end

    logic [NWP-1:0]  e_nx_reg, e_ny_reg;
    logic [2*SW-1:0] e_den_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_nx_reg  <= (NWP'(d_hx_reg) << LOW) + NWP'(d_lx_reg) + NWP'(d_d2_reg >> 1);
            e_ny_reg  <= (NWP'(d_hy_reg) << LOW) + NWP'(d_ly_reg) + NWP'(d_d2_reg >> 1);
            e_den_reg <= d_d2_reg;
        end
    end

    logic [QWP-1:0] qpx, qpy, qpx_al, qpy_al;

    cpcr_div #(.NW(NWP), .DW(2 * SW), .QW(QWP)) u_div_px (
        .aclk (aclk), .en (adv), .num (e_nx_reg), .den (e_den_reg), .quo (qpx)
    );

    cpcr_div #(.NW(NWP), .DW(2 * SW), .QW(QWP)) u_div_py (
        .aclk (aclk), .en (adv), .num (e_ny_reg), .den (e_den_reg), .quo (qpy)
    );

    cpcr_delay #(.W(2 * QWP), .DEPTH(LAT_M - LAT_P)) u_p_dly (
        .aclk (aclk),
        .en   (adv),
        .din  ({qpx, qpy}),
        .dout ({qpx_al, qpy_al})
    );

    // item side data held alongside the arithmetic
    logic [PLW-1:0] c_pl, m_pl;

    assign c_pl = {c_fld_reg[0], c_fld_reg[1], c_fld_reg[2], c_fld_reg[3],
                   c_fld_reg[4], c_fld_reg[5], c_fld_reg[6], c_fld_reg[7],
                   c_s_reg, c_rvx_reg, c_hit_reg, c_zero_reg,
                   c_sdx_reg, c_sdy_reg, c_dot_reg[DOTW-1]};

    cpcr_delay #(.W(PLW), .DEPTH(LAT_M)) u_pl_dly (
        .aclk (aclk),
        .en   (adv),
        .din  (c_pl),
        .dout (m_pl)
    );

    logic [CW-1:0]         m_fld [NF];
    logic [SW-1:0]         m_s;
    logic signed [DXW-1:0] m_rvx;
    logic                  m_hit, m_zero, m_sdx, m_sdy, m_sdot;

    assign {m_fld[0], m_fld[1], m_fld[2], m_fld[3], m_fld[4], m_fld[5], m_fld[6],
            m_fld[7], m_s, m_rvx, m_hit, m_zero, m_sdx, m_sdy, m_sdot} = m_pl;

    // stage F: apply push, form pre-damping velocities
    logic [SW:0]           half_s;
    logic signed [SW:0]    qux_s, quy_s, push_x, push_y;
    logic signed [PXW-1:0] qpx_s, qpy_s, px, py;
    logic signed [PSW-1:0] pos_sum [4];
    logic signed [VW-1:0]  vel_pre [4];

    assign half_s = ({1'b0, m_s} + (SW+1)'(1)) >> 1;
    assign qux_s  = {1'b0, qux_al};
    assign quy_s  = {1'b0, quy_al};
    assign qpx_s  = {1'b0, qpx_al};
    assign qpy_s  = {1'b0, qpy_al};
    assign push_x = m_zero ? half_s : (m_sdx ? -qux_s : qux_s);
    assign push_y = m_zero ? '0 : (m_sdy ? -quy_s : quy_s);
    assign px     = m_zero ? PXW'(m_rvx) : ((m_sdot ^ m_sdx) ? -qpx_s : qpx_s);
    assign py     = m_zero ? '0 : ((m_sdot ^ m_sdy) ? -qpy_s : qpy_s);

    assign pos_sum[0] = PSW'(signed'(m_fld[cpcr_pkg::F_APX])) + PSW'(push_x);
    assign pos_sum[1] = PSW'(signed'(m_fld[cpcr_pkg::F_APY])) + PSW'(push_y);
    assign pos_sum[2] = PSW'(signed'(m_fld[cpcr_pkg::F_BPX])) - PSW'(push_x);
    assign pos_sum[3] = PSW'(signed'(m_fld[cpcr_pkg::F_BPY])) - PSW'(push_y);
    assign vel_pre[0] = VW'(signed'(m_fld[cpcr_pkg::F_AVX])) - VW'(px);
    assign vel_pre[1] = VW'(signed'(m_fld[cpcr_pkg::F_AVY])) - VW'(py);
    assign vel_pre[2] = VW'(signed'(m_fld[cpcr_pkg::F_BVX])) + VW'(px);
    assign vel_pre[3] = VW'(signed'(m_fld[cpcr_pkg::F_BVY])) + VW'(py);

    logic [CW-1:0]        f_pos_reg [4];
    logic [CW-1:0]        f_vel_reg [4];
    logic signed [VW-1:0] f_v_reg   [4];
    logic                 f_hit_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_hit_reg <= m_hit;
            f_pos_reg[0] <= m_hit ? sat_c(SATW'(pos_sum[0])) : m_fld[cpcr_pkg::F_APX];
            f_pos_reg[1] <= m_hit ? sat_c(SATW'(pos_sum[1])) : m_fld[cpcr_pkg::F_APY];
            f_pos_reg[2] <= m_hit ? sat_c(SATW'(pos_sum[2])) : m_fld[cpcr_pkg::F_BPX];
            f_pos_reg[3] <= m_hit ? sat_c(SATW'(pos_sum[3])) : m_fld[cpcr_pkg::F_BPY];
            f_vel_reg[0] <= m_fld[cpcr_pkg::F_AVX];
            f_vel_reg[1] <= m_fld[cpcr_pkg::F_AVY];
            f_vel_reg[2] <= m_fld[cpcr_pkg::F_BVX];
            f_vel_reg[3] <= m_fld[cpcr_pkg::F_BVY];
            f_v_reg <= vel_pre;
        end
    end

    // stage G: damping multiply
    logic signed [DMW:0]   damp_s;
    logic signed [PDW-1:0] g_prod_reg [4];
    logic [CW-1:0]         g_pos_reg  [4];
    logic [CW-1:0]         g_vel_reg  [4];
    logic                  g_hit_reg;

    assign damp_s = {1'b0, damp_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_hit_reg <= f_hit_reg;
            g_pos_reg <= f_pos_reg;
            g_vel_reg <= f_vel_reg;
            for (int i = 0; i < 4; i++) begin
                g_prod_reg[i] <= f_v_reg[i] * damp_s;
            end
        end
    end

    // stage H: round, saturate, select
    logic [PDW-1:0]         g_mag [4];
    logic [PDW-1:0]         g_rq  [4];
    logic signed [SATW-1:0] g_val [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            g_mag[i] = g_prod_reg[i][PDW-1] ? -g_prod_reg[i] : g_prod_reg[i];
            g_rq[i]  = PDW'(((PDW+1)'(g_mag[i])
                      + ((PDW+1)'(1) << (cpcr_pkg::DAMP_SHIFT - 1))) >> cpcr_pkg::DAMP_SHIFT);
            g_val[i] = g_prod_reg[i][PDW-1] ? -SATW'(g_rq[i]) : SATW'(g_rq[i]);
        end
    end

    logic [CW-1:0] h_pos_reg [4];
    logic [CW-1:0] h_vel_reg [4];
    logic          h_hit_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_hit_reg <= g_hit_reg;
            h_pos_reg <= g_pos_reg;
            for (int i = 0; i < 4; i++) begin
                h_vel_reg[i] <= g_hit_reg ? sat_c(g_val[i]) : g_vel_reg[i];
            end
        end
    end

    // output register and skid
    logic [OW-1:0] h_out;
    logic [OW-1:0] out_reg, skid_reg;
    logic          out_valid_reg, skid_valid_reg;
    logic          pop, out_free;

    assign h_out = {h_pos_reg[0], h_pos_reg[1], h_vel_reg[0], h_vel_reg[1],
                    h_pos_reg[2], h_pos_reg[3], h_vel_reg[2], h_vel_reg[3], h_hit_reg};

    assign adv      = !skid_valid_reg;
    assign s_ready  = !skid_valid_reg;
    assign pop      = vld_reg[TOTAL-1] && adv;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= pop;
            end
        end else if (pop) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : h_out;
        end else if (pop) begin
            skid_reg <= h_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign {m_new_first_pos_x, m_new_first_pos_y, m_new_first_vel_x, m_new_first_vel_y,
            m_new_second_pos_x, m_new_second_pos_y, m_new_second_vel_x, m_new_second_vel_y,
            m_collided} = out_reg;

endmodule

>>> sim/circle_pair_collision_checker.sv
module circle_pair_collision_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cpcr_pkg::DAMP_WIDTH-1:0] cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [19:0]            s_first_pos_x,
    input  logic signed [19:0]            s_first_pos_y,
    input  logic signed [19:0]            s_first_vel_x,
    input  logic signed [19:0]            s_first_vel_y,
    input  logic [15:0]                   s_first_radius,
    input  logic signed [19:0]            s_second_pos_x,
    input  logic signed [19:0]            s_second_pos_y,
    input  logic signed [19:0]            s_second_vel_x,
    input  logic signed [19:0]            s_second_vel_y,
    input  logic [15:0]                   s_second_radius,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [19:0]            m_new_first_pos_x,
    input  logic signed [19:0]            m_new_first_pos_y,
    input  logic signed [19:0]            m_new_first_vel_x,
    input  logic signed [19:0]            m_new_first_vel_y,
    input  logic signed [19:0]            m_new_second_pos_x,
    input  logic signed [19:0]            m_new_second_pos_y,
    input  logic signed [19:0]            m_new_second_vel_x,
    input  logic signed [19:0]            m_new_second_vel_y,
    input  logic                          m_collided,
    output int                            fail_count,
    output int                            pending,
    output int                            hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_MAX = 524287;
    localparam longint COORD_MIN = -524288;

    typedef struct {
        logic signed [19:0] coord [cpcr_pkg::NUM_FIELDS];
        logic               collided;
    } resolved_pair_t;

    resolved_pair_t resolved_q [$];
    longint         damping;

    string field_name [cpcr_pkg::NUM_FIELDS] = '{"new_first_pos_x", "new_first_pos_y",
        "new_first_vel_x", "new_first_vel_y", "new_second_pos_x", "new_second_pos_y",
        "new_second_vel_x", "new_second_vel_y"};

    function automatic longint div_nearest(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint apply_damping(longint v, longint dmp);
        return clamp_coord(div_nearest(v * dmp, longint'(1) << cpcr_pkg::DAMP_SHIFT));
    endfunction

    function automatic resolved_pair_t resolve_pair(longint apx, longint apy, longint avx,
            longint avy, longint ra, longint bpx, longint bpy, longint bvx, longint bvy,
            longint rb, longint dmp);
        resolved_pair_t r;
        longint dx, dy, d2, s, centre_dist, depth, dot, pushx, pushy, px, py;
        longint v [cpcr_pkg::NUM_FIELDS];
        dx = apx - bpx;
        dy = apy - bpy;
        d2 = dx * dx + dy * dy;
        s = ra + rb;
        v[cpcr_pkg::F_APX] = apx; v[cpcr_pkg::F_APY] = apy;
        v[cpcr_pkg::F_AVX] = avx; v[cpcr_pkg::F_AVY] = avy;
        v[cpcr_pkg::F_BPX] = bpx; v[cpcr_pkg::F_BPY] = bpy;
        v[cpcr_pkg::F_BVX] = bvx; v[cpcr_pkg::F_BVY] = bvy;
        r.collided = d2 < s * s;
        if (r.collided) begin
            if (d2 == 0) begin
                pushx = div_nearest(s, 2);
                pushy = 0;
                px = avx - bvx;
                py = 0;
            end else begin
                centre_dist = floor_sqrt(d2);
                depth = s - centre_dist;
                dot = (avx - bvx) * dx + (avy - bvy) * dy;
                pushx = div_nearest(dx * depth, 2 * centre_dist);
                pushy = div_nearest(dy * depth, 2 * centre_dist);
                px = div_nearest(dot * dx, d2);
                py = div_nearest(dot * dy, d2);
            end
            v[cpcr_pkg::F_APX] = clamp_coord(apx + pushx);
            v[cpcr_pkg::F_APY] = clamp_coord(apy + pushy);
            v[cpcr_pkg::F_AVX] = apply_damping(avx - px, dmp);
            v[cpcr_pkg::F_AVY] = apply_damping(avy - py, dmp);
            v[cpcr_pkg::F_BPX] = clamp_coord(bpx - pushx);
            v[cpcr_pkg::F_BPY] = clamp_coord(bpy - pushy);
            v[cpcr_pkg::F_BVX] = apply_damping(bvx + px, dmp);
            v[cpcr_pkg::F_BVY] = apply_damping(bvy + py, dmp);
        end
        foreach (v[i]) r.coord[i] = v[i][19:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        resolved_pair_t got;
        resolved_pair_t want;
        if (!aresetn) begin
            damping <= cpcr_pkg::DAMP_RESET;
            resolved_q.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) damping <= cfg_wr_data;
            if (s_valid && s_ready)
                resolved_q.push_back(resolve_pair(s_first_pos_x, s_first_pos_y, s_first_vel_x,
                    s_first_vel_y, s_first_radius, s_second_pos_x, s_second_pos_y,
                    s_second_vel_x, s_second_vel_y, s_second_radius, damping));
            if (m_valid && m_ready) begin
                got.coord[cpcr_pkg::F_APX] = m_new_first_pos_x;
                got.coord[cpcr_pkg::F_APY] = m_new_first_pos_y;
                got.coord[cpcr_pkg::F_AVX] = m_new_first_vel_x;
                got.coord[cpcr_pkg::F_AVY] = m_new_first_vel_y;
                got.coord[cpcr_pkg::F_BPX] = m_new_second_pos_x;
                got.coord[cpcr_pkg::F_BPY] = m_new_second_pos_y;
                got.coord[cpcr_pkg::F_BVX] = m_new_second_vel_x;
                got.coord[cpcr_pkg::F_BVY] = m_new_second_vel_y;
                got.collided = m_collided;
                if (resolved_q.size() == 0) begin
                    $error("result item with nothing outstanding");
                    fail_count++;
                end else begin
                    want = resolved_q.pop_front();
                    if (want.collided) hits_seen <= hits_seen + 1;
                    foreach (want.coord[i])
                        if (want.coord[i] !== got.coord[i]) begin
                            $error("%s expected %0d got %0d", field_name[i],
                                want.coord[i], got.coord[i]);
                            fail_count++;
                        end
                    if (want.collided !== got.collided) begin
                        $error("collided expected %0d got %0d", want.collided, got.collided);
                        fail_count++;
                    end
                end
            end
            pending <= resolved_q.size();
        end
    end

    initial begin
        fail_count = 0;
        hits_seen = 0;
        pending = 0;
    end

endmodule

>>> sim/circle_pair_collision_resolve_unit_test.sv
module circle_pair_collision_resolve_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 100;
    localparam int DMW = cpcr_pkg::DAMP_WIDTH;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [DMW-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [19:0] s_first_pos_x = '0, s_first_pos_y = '0;
    logic signed [19:0] s_first_vel_x = '0, s_first_vel_y = '0;
    logic [15:0] s_first_radius = '0;
    logic signed [19:0] s_second_pos_x = '0, s_second_pos_y = '0;
    logic signed [19:0] s_second_vel_x = '0, s_second_vel_y = '0;
    logic [15:0] s_second_radius = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [19:0] m_new_first_pos_x, m_new_first_pos_y;
    logic signed [19:0] m_new_first_vel_x, m_new_first_vel_y;
    logic signed [19:0] m_new_second_pos_x, m_new_second_pos_y;
    logic signed [19:0] m_new_second_vel_x, m_new_second_vel_y;
    logic m_collided;
    int fail_count;
    int pending;
    int hits_seen;
    int pairs_sent = 0;
    bit calm = 1'b0;

    always #1 aclk = ~aclk;

    circle_pair_collision_resolve_unit #(.COORD_WIDTH(20)) i_dut (.*);

    circle_pair_collision_checker i_checker (.*);

    always @(posedge aclk)
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);

    task automatic send_pair(input logic signed [19:0] apx, apy, avx, avy,
            input logic [15:0] ra, input logic signed [19:0] bpx, bpy, bvx, bvy,
            input logic [15:0] rb);
        if (!calm && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_first_pos_x <= apx; s_first_pos_y <= apy;
        s_first_vel_x <= avx; s_first_vel_y <= avy; s_first_radius <= ra;
        s_second_pos_x <= bpx; s_second_pos_y <= bpy;
        s_second_vel_x <= bvx; s_second_vel_y <= bvy; s_second_radius <= rb;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_damping(input logic [DMW-1:0] value);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [19:0] any_coord();
        case ($urandom_range(3))
            0: return 20'sh7FFFF;
            1: return -20'sh80000;
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic send_random_pair();
        logic signed [19:0] apx, apy, bpx, bpy;
        logic [15:0] ra, rb;
        int span;
        int mode;
        mode = $urandom_range(99);
        ra = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384));
        rb = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384));
        apx = 20'($urandom_range(0, 20'hFFFFF));
        apy = 20'($urandom_range(0, 20'hFFFFF));
        span = int'(ra) + int'(rb);
        if (mode < 70) begin
            bpx = 20'(apx - ($urandom_range(0, 2 * span) - span));
            bpy = 20'(apy - ($urandom_range(0, 2 * span) - span));
        end else if (mode < 80) begin
            bpx = apx;
            bpy = apy;
        end else if (mode < 88) begin
            bpx = 20'(apx - span);
            bpy = apy;
        end else begin
            bpx = any_coord();
            bpy = any_coord();
            apx = any_coord();
        end
        send_pair(apx, apy, any_coord(), any_coord(), ra, bpx, bpy, any_coord(), any_coord(), rb);
    endtask

    initial begin
        #1ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        calm = 1'b1;
        send_pair(0, 0, 4096, 0, 4096, 4096, 0, -4096, 0, 4096);
        send_pair(100, 200, 300, -400, 8192, 100, 200, -500, 600, 8192);
        send_pair(5000, 5000, 0, 0, 0, 5000, 5000, 0, 0, 0);
        send_pair(8192, 0, 1, 1, 4096, 0, 0, 0, 0, 4096);
        send_pair(0, 3000, 7, 9, 2500, 0, 0, 3, 5, 2500);
        send_pair(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 16'hFFFF,
                  20'sh7FF00, 20'sh7FF00, -20'sh80000, -20'sh80000, 16'hFFFF);
        send_pair(-20'sh80000, -20'sh80000, -20'sh80000, 20'sh7FFFF, 16'hFFFF,
                  -20'sh7FF00, -20'sh80000, 20'sh7FFFF, -20'sh80000, 16'hFFFF);
        send_pair(20'sh7FFFF, -20'sh80000, 0, 0, 16'hFFFF, -20'sh80000, 20'sh7FFFF,
                  0, 0, 16'hFFFF);
        send_pair(-20'sh80000, 0, -20'sh80000, -20'sh80000, 16'hFFFF, -20'sh80000, 0,
                  20'sh7FFFF, 20'sh7FFFF, 16'hFFFF);
        send_pair(1000, -1000, -20000, 30000, 300, 1200, -1100, 40000, -50000, 400);
        send_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);

        set_damping(17'd65536);
        send_pair(0, 0, 20'sh7FFFF, 0, 16'hFFFF, 100, 0, -20'sh80000, 0, 16'hFFFF);
        set_damping(17'd0);
        send_pair(0, 0, 12345, -6789, 4096, 1000, 1000, -2222, 3333, 4096);
        set_damping(17'h1FFFF);
        send_pair(0, 0, 20'sh40000, 20'sh40000, 4096, 10, 10, -20'sh40000, 20'sh3000, 4096);
        calm = 1'b0;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_damping(cpcr_pkg::DAMP_RESET);
                1: set_damping(17'h1FFFF);
                2: set_damping(17'd0);
                default: set_damping(DMW'($urandom_range(1, 65536)));
            endcase
            for (int n = 0; n < 135; n++) begin
                calm = (phase == 2) && (n >= 30) && (n < 100);
                send_random_pair();
            end
        end
        calm = 1'b0;
        quiesce();

        $display("sent %0d disc pairs, %0d resolved as collisions, across four damping settings",
                 pairs_sent, hits_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
rtl/cpcr_pkg.sv
rtl/cpcr_delay.sv
rtl/cpcr_isqrt.sv
rtl/cpcr_div.sv
rtl/circle_pair_collision_resolve_unit.sv
sim/circle_pair_collision_checker.sv
sim/circle_pair_collision_resolve_unit_test.sv
